[hdl/pps_pkg.sv]
// pps_pkg: shared types, constants and the cordic angle table for the pure pursuit
// steering block; used by pure_pursuit_steering and pps_checker
package pps_pkg;

  localparam int MAX_WAYPOINTS_DEF = 1024;
  localparam int SEARCH_WINDOW_DEF = 32;

  localparam int CNT_W      = 11;
  localparam int POS_W      = 48;
  localparam int QUAT_W     = 16;
  localparam int STEER_W    = 16;
  localparam int TIDX_W     = 10;
  localparam int WIDX_W     = 10;
  localparam int CFG_W      = 32;
  localparam int MAXD_W     = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_W       = 224;
  localparam int OUT_W      = 32;

  localparam int ANG_W      = 34;
  localparam int VEC_W      = 56;
  localparam int NSTEP      = 30;
  localparam int IT_W       = 5;
  localparam int SH_W       = 5;
  localparam int DVD_W      = 36;
  localparam int DVS_W      = MAXD_W + 6;

  localparam logic [29:0] CORDIC_K = 30'd652032874;
  localparam logic signed [ANG_W-1:0] HALF_PI = ANG_W'(64'sd1073741824);
  localparam logic signed [ANG_W-1:0] PI      = ANG_W'(64'sd2147483648);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOKAHEAD,
    CFG_WHEEL_BASE,
    CFG_MAX_STEER,
    CFG_WAYPOINT_COUNT
  } cfg_idx_t;

  typedef enum logic [1:0] {
    U_YAW,
    U_BEAR,
    U_SIN,
    U_THETA
  } cord_use_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_POSE,
    ST_SCHK,
    ST_SDIFF,
    ST_SQ0,
    ST_SQ1,
    ST_SQ2,
    ST_SQ3,
    ST_SCMP,
    ST_TRD,
    ST_QMUL,
    ST_QLAST,
    ST_QCALC,
    ST_VNORM,
    ST_CITER,
    ST_CEND,
    ST_DMUL,
    ST_DCAP,
    ST_SINSET,
    ST_NMUL,
    ST_NCAP,
    ST_CMUL,
    ST_CCAP,
    ST_DIV,
    ST_DEND,
    ST_OUT
  } state_t;

  function automatic logic [29:0] atan_entry(input logic [IT_W-1:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:    r = 30'd536870912;
      5'd1:    r = 30'd316933406;
      5'd2:    r = 30'd167458907;
      5'd3:    r = 30'd85004756;
      5'd4:    r = 30'd42667331;
      5'd5:    r = 30'd21354465;
      5'd6:    r = 30'd10679838;
      5'd7:    r = 30'd5340245;
      5'd8:    r = 30'd2670163;
      5'd9:    r = 30'd1335087;
      5'd10:   r = 30'd667544;
      5'd11:   r = 30'd333772;
      5'd12:   r = 30'd166886;
      5'd13:   r = 30'd83443;
      5'd14:   r = 30'd41722;
      5'd15:   r = 30'd20861;
      5'd16:   r = 30'd10430;
      5'd17:   r = 30'd5215;
      5'd18:   r = 30'd2608;
      5'd19:   r = 30'd1304;
      5'd20:   r = 30'd652;
      5'd21:   r = 30'd326;
      5'd22:   r = 30'd163;
      5'd23:   r = 30'd81;
      5'd24:   r = 30'd41;
      5'd25:   r = 30'd20;
      5'd26:   r = 30'd10;
      5'd27:   r = 30'd5;
      5'd28:   r = 30'd3;
      5'd29:   r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

[hdl/pure_pursuit_steering.sv]
// pure_pursuit_steering: top level, waypoint memory, search sequencer and shared
// cordic, multiplier and divider; depends on pps_pkg
//
// Each beat in gives one beat out. A load beat (tuser 0) writes one waypoint, if its
// index is in range, and returns the last command. A pose beat (tuser 1) searches the
// window ahead of the current target, reading each slot from the waypoint memory over
// its one read port, then runs yaw, bearing, sine and steering angle one after another
// through a single iterative cordic and a 36-step divider. The input side is ready
// again as soon as a result sits in the output register.
module pure_pursuit_steering #(
  parameter int MAX_WAYPOINTS = pps_pkg::MAX_WAYPOINTS_DEF,
  parameter int SEARCH_WINDOW = pps_pkg::SEARCH_WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // wypt_index, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w
  input  logic [pps_pkg::IN_W-1:0]         s_tdata,
  // mode
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // steer_cmd, target_index, within_lookahead
  output logic [pps_pkg::OUT_W-1:0]        m_tdata,
  input  logic                             cfg_we,
  input  logic [pps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pps_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int AW   = $clog2(MAX_WAYPOINTS);
  localparam int KW   = $clog2(SEARCH_WINDOW + 1);
  localparam int LW   = (AW + 1 > pps_pkg::CNT_W) ? AW + 1 : pps_pkg::CNT_W;
  localparam int IDXW = ((LW > KW) ? LW : KW) + 1;
  localparam int AN   = pps_pkg::ANG_W;
  localparam int VW   = pps_pkg::VEC_W;

  function automatic logic [48:0] mag49(input logic signed [48:0] v);
    return v[48] ? 49'(-v) : 49'(v);
  endfunction

  function automatic logic [35:0] mag36(input logic signed [35:0] v);
    return v[35] ? 36'(-v) : 36'(v);
  endfunction

  function automatic logic [AN-1:0] mag_an(input logic signed [AN-1:0] v);
    return v[AN-1] ? AN'(-v) : AN'(v);
  endfunction

  // shift toward zero
  function automatic logic signed [AN-1:0] asr(input logic signed [AN-1:0] v,
                                               input logic [pps_pkg::IT_W-1:0] s);
    logic [AN-1:0] m;
    m = mag_an(v) >> s;
    return v[AN-1] ? -$signed(m) : $signed(m);
  endfunction

  pps_pkg::state_t state, state_next;

  // configuration
  logic [31:0]                  lookahead, wheel_base;
  logic [pps_pkg::MAXD_W-1:0]   max_steer;
  logic [pps_pkg::CNT_W-1:0]    wp_count;

  // waypoint memory, {y, x}
  logic [2*pps_pkg::POS_W-1:0]  mem [MAX_WAYPOINTS];
  logic [2*pps_pkg::POS_W-1:0]  rdata;
  logic                         rd_en, wr_en;
  logic [AW-1:0]                rd_addr;

  // persistent state
  logic [AW-1:0]                target;
  logic signed [15:0]           last_steer;
  logic                         last_within;

  // pose
  logic signed [47:0]           px, py, pz;
  logic signed [15:0]           qx, qy, qz, qw;

  // search
  logic [KW-1:0]                k;
  logic [IDXW-1:0]              idx, tgt_ext;
  logic [LW-1:0]                lim;
  logic [63:0]                  lim2, acc;
  logic                         ovf, far, fin, dz;
  logic [31:0]                  ma, mb, mc;
  logic signed [48:0]           dxs, dys;

  // shared multiplier
  logic [31:0]                  mul_a, mul_b;
  logic [63:0]                  prod;

  // quaternion products
  logic [2:0]                   qstep;
  logic                         psign;
  logic signed [31:0]           qp [8];
  logic signed [15:0]           qa, qb;

  // cordic
  pps_pkg::cord_use_t           cuse;
  logic                         rot, vsx, vsy;
  logic [VW-1:0]                vax, vay;
  logic [pps_pkg::SH_W-1:0]     sh;
  logic signed [AN-1:0]         cx, cy, cz;
  logic [pps_pkg::IT_W-1:0]     it;
  logic signed [AN-1:0]         yaw, alpha, sn, theta, zres, alpha_now;
  logic [31:0]                  gm;
  logic [VW-1:0]                d16;

  // divider
  logic [pps_pkg::DVD_W-1:0]    dvd;
  logic [pps_pkg::DVS_W:0]      rem;
  logic [5:0]                   dcnt;
  logic                         out_load;

  assign lim = (LW'(wp_count) < LW'(MAX_WAYPOINTS)) ? LW'(wp_count) : LW'(MAX_WAYPOINTS);
  assign idx = IDXW'(target) + IDXW'(k);
  assign tgt_ext = IDXW'(target);
  assign wr_en = (state == pps_pkg::ST_IDLE) && s_tvalid && !s_tuser &&
                 (LW'(s_tdata[9:0]) < LW'(MAX_WAYPOINTS));
  assign out_load = (state == pps_pkg::ST_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    unique case (qstep)
      3'd0:    begin qa = qx; qb = qx; end
      3'd1:    begin qa = qy; qb = qy; end
      3'd2:    begin qa = qz; qb = qz; end
      3'd3:    begin qa = qw; qb = qw; end
      3'd4:    begin qa = qx; qb = qz; end
      3'd5:    begin qa = qw; qb = qy; end
      3'd6:    begin qa = qx; qb = qy; end
      default: begin qa = qw; qb = qz; end
    endcase
  end

  // vectoring result with quadrant
  always_comb begin
    logic signed [AN-1:0] zc;
    zc = cz[AN-1] ? '0 : ((cz > pps_pkg::HALF_PI) ? pps_pkg::HALF_PI : cz);
    if (vsx) zc = pps_pkg::PI - zc;
    if (vsy) zc = -zc;
    zres = zc;
  end

  assign alpha_now = yaw - zres;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = target;
    mul_a      = lookahead;
    mul_b      = lookahead;
    unique case (state)
      pps_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = s_tuser ? pps_pkg::ST_POSE : pps_pkg::ST_OUT;
      end
      pps_pkg::ST_POSE: state_next = pps_pkg::ST_SCHK;
      pps_pkg::ST_SCHK: begin
        if (k == '0) begin
          state_next = pps_pkg::ST_TRD;
        end else if (idx < IDXW'(lim)) begin
          rd_en      = 1'b1;
          rd_addr    = idx[AW-1:0];
          state_next = pps_pkg::ST_SDIFF;
        end
      end
      pps_pkg::ST_TRD: begin
        rd_en      = 1'b1;
        state_next = pps_pkg::ST_SDIFF;
      end
      pps_pkg::ST_SDIFF: state_next = pps_pkg::ST_SQ0;
      pps_pkg::ST_SQ0: begin
        mul_a = ma; mul_b = ma;
        state_next = pps_pkg::ST_SQ1;
      end
      pps_pkg::ST_SQ1: begin
        mul_a = mb; mul_b = mb;
        state_next = pps_pkg::ST_SQ2;
      end
      pps_pkg::ST_SQ2: begin
        mul_a = mc; mul_b = mc;
        state_next = pps_pkg::ST_SQ3;
      end
      pps_pkg::ST_SQ3: state_next = pps_pkg::ST_SCMP;
      pps_pkg::ST_SCMP: begin
        if (fin) state_next = pps_pkg::ST_QMUL;
        else if (!far && !ovf && acc < lim2) state_next = pps_pkg::ST_TRD;
        else state_next = pps_pkg::ST_SCHK;
      end
      pps_pkg::ST_QMUL: begin
        mul_a = 32'(mag_an(AN'(qa)));
        mul_b = 32'(mag_an(AN'(qb)));
        if (qstep == 3'd7) state_next = pps_pkg::ST_QLAST;
      end
      pps_pkg::ST_QLAST: state_next = pps_pkg::ST_QCALC;
      pps_pkg::ST_QCALC: state_next = pps_pkg::ST_VNORM;
      pps_pkg::ST_VNORM: begin
        if ((vax | vay) < VW'(64'd1073741824)) state_next = pps_pkg::ST_CITER;
      end
      pps_pkg::ST_CITER: begin
        if (it == pps_pkg::IT_W'(pps_pkg::NSTEP - 1)) state_next = pps_pkg::ST_CEND;
      end
      pps_pkg::ST_CEND: begin
        unique case (cuse)
          pps_pkg::U_YAW:   state_next = pps_pkg::ST_VNORM;
          pps_pkg::U_BEAR:  state_next = dz ? pps_pkg::ST_CMUL : pps_pkg::ST_DMUL;
          pps_pkg::U_SIN:   state_next = pps_pkg::ST_NMUL;
          pps_pkg::U_THETA: state_next = pps_pkg::ST_CMUL;
        endcase
      end
      pps_pkg::ST_DMUL: begin
        mul_a = gm; mul_b = 32'(pps_pkg::CORDIC_K);
        state_next = pps_pkg::ST_DCAP;
      end
      pps_pkg::ST_DCAP:   state_next = pps_pkg::ST_SINSET;
      pps_pkg::ST_SINSET: state_next = pps_pkg::ST_CITER;
      pps_pkg::ST_NMUL: begin
        mul_a = wheel_base; mul_b = 32'(mag_an(sn));
        state_next = pps_pkg::ST_NCAP;
      end
      pps_pkg::ST_NCAP: state_next = pps_pkg::ST_VNORM;
      pps_pkg::ST_CMUL: begin
        mul_a = 32'(mag_an(theta)); mul_b = 32'd45;
        state_next = (max_steer == '0) ? pps_pkg::ST_OUT : pps_pkg::ST_CCAP;
      end
      pps_pkg::ST_CCAP: state_next = pps_pkg::ST_DIV;
      pps_pkg::ST_DIV: begin
        if (dcnt == 6'(pps_pkg::DVD_W - 1)) state_next = pps_pkg::ST_DEND;
      end
      pps_pkg::ST_DEND: state_next = pps_pkg::ST_OUT;
      pps_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) state_next = pps_pkg::ST_IDLE;
      end
      default: state_next = pps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pps_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[s_tdata[AW-1+10-10:0] & AW'(s_tdata[9:0])] <= s_tdata[105:10];
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead   <= 32'd327680;
      wheel_base  <= 32'd98304;
      max_steer   <= 15'd7680;
      wp_count    <= '0;
      target      <= '0;
      last_steer  <= '0;
      last_within <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (pps_pkg::cfg_idx_t'(cfg_index))
          pps_pkg::CFG_LOOKAHEAD:      lookahead  <= cfg_wdata;
          pps_pkg::CFG_WHEEL_BASE:     wheel_base <= cfg_wdata;
          pps_pkg::CFG_MAX_STEER:      max_steer  <= cfg_wdata[pps_pkg::MAXD_W-1:0];
          pps_pkg::CFG_WAYPOINT_COUNT: wp_count   <= cfg_wdata[pps_pkg::CNT_W-1:0];
        endcase
      end
      if (state == pps_pkg::ST_SCMP) begin
        if (fin) last_within <= !far && !ovf && acc < lim2;
        else if (!far && !ovf && acc < lim2) target <= idx[AW-1:0];
      end
      if (state == pps_pkg::ST_CMUL && max_steer == '0) last_steer <= '0;
      if (state == pps_pkg::ST_DEND) begin
        if (theta[AN-1]) last_steer <= (dvd > 36'd32768) ? -16'sd32768 : -$signed(dvd[15:0]);
        else last_steer <= (dvd > 36'd32767) ? 16'sd32767 : $signed(dvd[15:0]);
      end
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    logic signed [48:0]   dx, dy;
    logic [48:0]          adx, ady, apz;
    logic signed [35:0]   n, g, vy, vx;
    logic signed [AN-1:0] shx, shy, s;
    logic [29:0]          tab;
    logic                 plus;
    logic [pps_pkg::DVS_W:0] rs;
    logic [64:0]          sum;
    unique case (state)
      pps_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          px <= s_tdata[57:10];
          py <= s_tdata[105:58];
          pz <= s_tdata[153:106];
          qx <= s_tdata[169:154];
          qy <= s_tdata[185:170];
          qz <= s_tdata[201:186];
          qw <= s_tdata[217:202];
        end
      end
      pps_pkg::ST_POSE: begin
        lim2 <= prod;
        k    <= KW'(SEARCH_WINDOW);
        fin  <= 1'b0;
      end
      pps_pkg::ST_SCHK: begin
        if (k != '0 && idx >= IDXW'(lim)) k <= k - 1'b1;
      end
      pps_pkg::ST_TRD: fin <= 1'b1;
      pps_pkg::ST_SDIFF: begin
        dx  = {rdata[47], rdata[47:0]} - {px[47], px};
        dy  = {rdata[95], rdata[95:48]} - {py[47], py};
        adx = mag49(dx);
        ady = mag49(dy);
        apz = fin ? '0 : mag49({pz[47], pz});
        dxs <= dx;
        dys <= dy;
        dz  <= (dx == '0) && (dy == '0);
        ma  <= adx[31:0];
        mb  <= ady[31:0];
        mc  <= apz[31:0];
        far <= (adx[48:32] != '0) || (ady[48:32] != '0) || (apz[48:32] != '0);
      end
      pps_pkg::ST_SQ1: begin
        acc <= prod;
        ovf <= 1'b0;
      end
      pps_pkg::ST_SQ2, pps_pkg::ST_SQ3: begin
        sum = {1'b0, acc} + {1'b0, prod};
        acc <= sum[63:0];
        ovf <= ovf | sum[64];
      end
      pps_pkg::ST_SCMP: begin
        qstep <= '0;
        if (!fin && !(!far && !ovf && acc < lim2)) k <= k - 1'b1;
      end
      pps_pkg::ST_QMUL: begin
        if (qstep != '0) qp[3'(qstep - 3'd1)] <= psign ? -$signed(prod[31:0])
                                                       : $signed(prod[31:0]);
        psign <= qa[15] ^ qb[15];
        qstep <= qstep + 1'b1;
      end
      pps_pkg::ST_QLAST: qp[7] <= psign ? -$signed(prod[31:0]) : $signed(prod[31:0]);
      pps_pkg::ST_QCALC: begin
        n  = 36'(qp[0]) + 36'(qp[1]) + 36'(qp[2]) + 36'(qp[3]);
        g  = 36'(qp[4]) - 36'(qp[5]);
        vy = 36'(qp[6]) + 36'(qp[7]);
        vy = vy <<< 1;
        vx = n - ((36'(qp[1]) + 36'(qp[2])) <<< 1);
        sh <= '0;
        if ((mag36(g) << 1) >= 36'(n)) begin
          // gimbal lock or null quaternion
          yaw  <= '0;
          cuse <= pps_pkg::U_BEAR;
          vax  <= VW'(mag49(dxs));
          vay  <= VW'(mag49(dys));
          vsx  <= dxs[48];
          vsy  <= dys[48];
        end else begin
          cuse <= pps_pkg::U_YAW;
          vax  <= VW'(mag36(vx));
          vay  <= VW'(mag36(vy));
          vsx  <= vx[35];
          vsy  <= vy[35];
        end
      end
      pps_pkg::ST_VNORM: begin
        if ((vax | vay) >= VW'(64'd1073741824)) begin
          vax <= vax >> 1;
          vay <= vay >> 1;
          sh  <= sh + 1'b1;
        end else begin
          cx  <= AN'(vax[29:0]);
          cy  <= AN'(vay[29:0]);
          cz  <= '0;
          it  <= '0;
          rot <= 1'b0;
        end
      end
      pps_pkg::ST_CITER: begin
        shx  = asr(cx, it);
        shy  = asr(cy, it);
        tab  = pps_pkg::atan_entry(it);
        plus = rot ? !cz[AN-1] : cy[AN-1];
        if (plus) begin
          cx <= cx - shy;
          cy <= cy + shx;
          cz <= cz - AN'(tab);
        end else begin
          cx <= cx + shy;
          cy <= cy - shx;
          cz <= cz + AN'(tab);
        end
        it <= it + 1'b1;
      end
      pps_pkg::ST_CEND: begin
        unique case (cuse)
          pps_pkg::U_YAW: begin
            yaw  <= zres;
            cuse <= pps_pkg::U_BEAR;
            sh   <= '0;
            vax  <= VW'(mag49(dxs));
            vay  <= VW'(mag49(dys));
            vsx  <= dxs[48];
            vsy  <= dys[48];
          end
          pps_pkg::U_BEAR: begin
            alpha <= alpha_now;
            gm    <= cx[31:0];
            if (alpha_now[AN-1]) theta <= -pps_pkg::HALF_PI;
            else if (alpha_now != '0) theta <= pps_pkg::HALF_PI;
            else theta <= '0;
          end
          pps_pkg::U_SIN: begin
            if (cy > pps_pkg::HALF_PI) sn <= pps_pkg::HALF_PI;
            else if (cy < -pps_pkg::HALF_PI) sn <= -pps_pkg::HALF_PI;
            else sn <= cy;
          end
          pps_pkg::U_THETA: theta <= zres;
        endcase
      end
      pps_pkg::ST_DCAP: d16 <= VW'(prod >> 30) << sh;
      pps_pkg::ST_SINSET: begin
        s = AN'($signed(alpha[31:0]));
        if (s > pps_pkg::HALF_PI) s = pps_pkg::PI - s;
        else if (s < -pps_pkg::HALF_PI) s = -pps_pkg::PI - s;
        cx   <= AN'(pps_pkg::CORDIC_K);
        cy   <= '0;
        cz   <= s;
        it   <= '0;
        rot  <= 1'b1;
        cuse <= pps_pkg::U_SIN;
      end
      pps_pkg::ST_NCAP: begin
        vax  <= d16;
        vay  <= VW'(prod >> 29);
        vsx  <= 1'b0;
        vsy  <= sn[AN-1] && ((prod >> 29) != '0);
        sh   <= '0;
        cuse <= pps_pkg::U_THETA;
      end
      pps_pkg::ST_CCAP: begin
        dvd  <= prod[pps_pkg::DVD_W-1:0];
        rem  <= '0;
        dcnt <= '0;
      end
      pps_pkg::ST_DIV: begin
        rs = {rem[pps_pkg::DVS_W-1:0], dvd[pps_pkg::DVD_W-1]};
        if (rs >= {1'b0, max_steer, 6'd0}) begin
          rem <= rs - {1'b0, max_steer, 6'd0};
          dvd <= {dvd[pps_pkg::DVD_W-2:0], 1'b1};
        end else begin
          rem <= rs;
          dvd <= {dvd[pps_pkg::DVD_W-2:0], 1'b0};
        end
        dcnt <= dcnt + 1'b1;
      end
      pps_pkg::ST_OUT: begin
        if (out_load) m_tdata <= {5'd0, last_within, tgt_ext[9:0], last_steer};
      end
      default: ;
    endcase
  end

endmodule

[hdl/pps_checker.sv]
// pps_checker: port-level checks for pure_pursuit_steering, bound to the top level
// depends on pps_pkg for the output width
module pps_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [pps_pkg::OUT_W-1:0] m_tdata
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat dropped or changed while stalled");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after an accepted beat");

  // a new result comes only as the sequencer frees up
  a_result_end: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready && $past(!s_tready))
    else $error("result beat without a finished item");

endmodule

bind pure_pursuit_steering pps_checker u_pps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
